### hw/rtl/ray_ground_classifier_macros.svh
// assertion macros for the ray ground classifier
`ifndef RAY_GROUND_CLASSIFIER_MACROS_SVH
`define RAY_GROUND_CLASSIFIER_MACROS_SVH

// same-cycle implication, checked out of reset
`define RGC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define RGC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/rgc_pkg.sv
// shared types and constants of the ray ground classifier
package rgc_pkg;

    localparam int IDX_W      = 17;
    localparam int RAD_W      = 18;
    localparam int H_W        = 16;
    localparam int TAN_W      = 16;
    localparam int WIN_W      = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int QUEUE_DEPTH = 8;

    localparam logic [WIN_W-1:0] H_MAX = 15'd32767;

    localparam logic [TAN_W-1:0] RST_TAN_LOCAL   = 16'd9210;
    localparam logic [TAN_W-1:0] RST_TAN_GENERAL = 16'd5734;
    localparam logic [WIN_W-1:0] RST_MIN_WINDOW  = 15'd50;
    localparam logic [RAD_W-1:0] RST_RING        = 18'd10;
    localparam logic [RAD_W-1:0] RST_GAP         = 18'd200;
    localparam logic [WIN_W-1:0] RST_SENSOR      = 15'd1750;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TAN_LOCAL   = 3'd0,
        CFG_TAN_GENERAL = 3'd1,
        CFG_MIN_WINDOW  = 3'd2,
        CFG_RING        = 3'd3,
        CFG_GAP         = 3'd4,
        CFG_SENSOR      = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [TAN_W-1:0] tan_local;
        logic [TAN_W-1:0] tan_general;
        logic [WIN_W-1:0] min_window;
        logic [RAD_W-1:0] ring;
        logic [RAD_W-1:0] gap;
        logic [WIN_W-1:0] sensor;
    } t_cfg;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             first;
        logic             in_local;
        logic             in_general;
        logic             reclass;
    } t_q_entry;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

### hw/rtl/rgc_front.sv
// front pipeline: takes points, computes thresholds and window flags
module rgc_front #(
    parameter int QueueDepth = rgc_pkg::QUEUE_DEPTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  rgc_pkg::t_cfg                        i_cfg,
    input  logic                                 i_push,
    input  logic                                 i_first,
    input  logic [rgc_pkg::RAD_W-1:0]            i_radius,
    input  logic signed [rgc_pkg::H_W-1:0]       i_height,
    input  logic [rgc_pkg::IDX_W-1:0]            i_index,
    output logic                                 o_full,
    input  logic                                 i_q_rd,
    output logic                                 o_q_wr,
    output rgc_pkg::t_q_entry                    o_q_wdata
);
    localparam int CntW  = $clog2(QueueDepth + 1);
    localparam int DW    = rgc_pkg::RAD_W + 1;
    localparam int ProdW = rgc_pkg::TAN_W + rgc_pkg::RAD_W;
    localparam int SumW  = rgc_pkg::H_W + 2;

    logic [CntW-1:0]                   r_cnt;
    logic [rgc_pkg::RAD_W-1:0]         r_last_r;
    logic signed [rgc_pkg::H_W-1:0]    r_last_h;

    logic                              r_s1_vld;
    logic signed [DW-1:0]              r_s1_d;
    logic signed [rgc_pkg::H_W-1:0]    r_s1_h;
    logic signed [rgc_pkg::H_W-1:0]    r_s1_lh;
    logic [rgc_pkg::IDX_W-1:0]         r_s1_idx;
    logic                              r_s1_first;
    logic [rgc_pkg::RAD_W-1:0]         r_s1_rad;

    logic                              r_s2_vld;
    logic [rgc_pkg::RAD_W-1:0]         r_s2_pl;
    logic [rgc_pkg::RAD_W-1:0]         r_s2_pg;
    logic signed [DW-1:0]              r_s2_d;
    logic signed [rgc_pkg::H_W-1:0]    r_s2_h;
    logic signed [rgc_pkg::H_W-1:0]    r_s2_lh;
    logic [rgc_pkg::IDX_W-1:0]         r_s2_idx;
    logic                              r_s2_first;

    logic                              accept;
    logic [CntW-1:0]                   n_cnt;
    logic signed [rgc_pkg::H_W-1:0]    ground_z;
    logic [rgc_pkg::RAD_W-1:0]         eff_lr;
    logic signed [rgc_pkg::H_W-1:0]    eff_lh;
    logic signed [DW-1:0]              n_d;
    logic signed [DW-1:0]              neg_d;
    logic [rgc_pkg::RAD_W-1:0]         abs_d;
    logic [ProdW-1:0]                  prod_l;
    logic [ProdW-1:0]                  prod_g;
    logic [rgc_pkg::WIN_W-1:0]         mag_l;
    logic [rgc_pkg::WIN_W-1:0]         mag_g;
    logic signed [rgc_pkg::H_W-1:0]    t_raw;
    logic signed [rgc_pkg::H_W-1:0]    t_fin;
    logic signed [rgc_pkg::H_W-1:0]    min_s;
    logic                              over_ring;
    logic                              over_gap;
    logic signed [SumW-1:0]            h_e;
    logic signed [SumW-1:0]            lh_e;
    logic signed [SumW-1:0]            t_e;
    logic signed [SumW-1:0]            gz_e;
    logic signed [SumW-1:0]            g_e;

    assign o_full = (r_cnt == CntW'(QueueDepth));
    assign accept = i_push && !o_full;

    // credits cover every item between input and queue read
    always_comb begin
        n_cnt = r_cnt;
        case ({accept, i_q_rd})
            2'b10:   n_cnt = r_cnt + CntW'(1);
            2'b01:   n_cnt = r_cnt - CntW'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    // stage one: step from the previous point of the ray
    assign ground_z = -$signed({1'b0, i_cfg.sensor});
    assign eff_lr   = i_first ? '0 : r_last_r;
    assign eff_lh   = i_first ? ground_z : r_last_h;
    assign n_d      = $signed({1'b0, i_radius}) - $signed({1'b0, eff_lr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_last_r <= '0;
            r_last_h <= '0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_cnt    <= n_cnt;
            r_s1_vld <= accept;
            r_s2_vld <= r_s1_vld;
            if (accept) begin
                r_last_r <= i_radius;
                r_last_h <= i_height;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_d     <= n_d;
            r_s1_h     <= i_height;
            r_s1_lh    <= eff_lh;
            r_s1_idx   <= i_index;
            r_s1_first <= i_first;
            r_s1_rad   <= i_radius;
        end
    end

    // stage two: slope products
    assign neg_d  = -r_s1_d;
    assign abs_d  = r_s1_d[DW-1] ? neg_d[rgc_pkg::RAD_W-1:0] : r_s1_d[rgc_pkg::RAD_W-1:0];
    assign prod_l = ProdW'(i_cfg.tan_local) * ProdW'(abs_d);
    assign prod_g = ProdW'(i_cfg.tan_general) * ProdW'(r_s1_rad);

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_s2_pl    <= prod_l[ProdW-1:rgc_pkg::TAN_W];
            r_s2_pg    <= prod_g[ProdW-1:rgc_pkg::TAN_W];
            r_s2_d     <= r_s1_d;
            r_s2_h     <= r_s1_h;
            r_s2_lh    <= r_s1_lh;
            r_s2_idx   <= r_s1_idx;
            r_s2_first <= r_s1_first;
        end
    end

    // stage three: saturation, minimum and window tests
    assign mag_l = (r_s2_pl > rgc_pkg::RAD_W'(rgc_pkg::H_MAX)) ?
                   rgc_pkg::H_MAX : r_s2_pl[rgc_pkg::WIN_W-1:0];
    assign mag_g = (r_s2_pg > rgc_pkg::RAD_W'(rgc_pkg::H_MAX)) ?
                   rgc_pkg::H_MAX : r_s2_pg[rgc_pkg::WIN_W-1:0];
    assign t_raw = r_s2_d[DW-1] ? -$signed({1'b0, mag_l}) : $signed({1'b0, mag_l});
    assign min_s = $signed({1'b0, i_cfg.min_window});
    assign over_ring = r_s2_d > $signed({1'b0, i_cfg.ring});
    assign over_gap  = r_s2_d > $signed({1'b0, i_cfg.gap});
    assign t_fin = (over_ring && (t_raw < min_s)) ? min_s : t_raw;

    assign h_e  = SumW'(r_s2_h);
    assign lh_e = SumW'(r_s2_lh);
    assign t_e  = SumW'(t_fin);
    assign gz_e = -$signed({3'b000, i_cfg.sensor});
    assign g_e  = $signed({3'b000, mag_g});

    assign o_q_wr = r_s2_vld;

    always_comb begin
        o_q_wdata.idx        = r_s2_idx;
        o_q_wdata.first      = r_s2_first;
        o_q_wdata.in_local   = (h_e <= lh_e + t_e) && (h_e >= lh_e - t_e);
        o_q_wdata.in_general = (h_e <= gz_e + g_e) && (h_e >= gz_e - g_e);
        o_q_wdata.reclass    = over_gap && (h_e <= gz_e + t_e) && (h_e >= gz_e - t_e);
    end

endmodule

### hw/rtl/rgc_queue.sv
// small queue between the front and the back
module rgc_queue #(
    parameter int QueueDepth = rgc_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr,
    input  rgc_pkg::t_q_entry  i_wdata,
    input  logic               i_rd,
    output rgc_pkg::t_q_entry  o_rdata,
    output rgc_pkg::t_q_stat   o_stat
);
    localparam int PtrW = $clog2(QueueDepth);
    localparam int CntW = $clog2(QueueDepth + 1);

    rgc_pkg::t_q_entry r_mem [QueueDepth];
    logic [PtrW-1:0]   r_wr_ptr;
    logic [PtrW-1:0]   r_rd_ptr;
    logic [CntW-1:0]   r_count;
    logic [CntW-1:0]   n_count;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CntW'(QueueDepth));
    assign o_rdata      = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        case ({i_wr, i_rd})
            2'b10:   n_count = r_count + CntW'(1);
            2'b01:   n_count = r_count - CntW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_wr) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : r_wr_ptr + PtrW'(1);
            end
            if (i_rd) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : r_rd_ptr + PtrW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

### hw/rtl/rgc_back.sv
// back end: chains the ground label along the ray and holds the result
module rgc_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rgc_pkg::t_q_entry          i_q_rdata,
    input  rgc_pkg::t_q_stat           i_q_stat,
    output logic                       o_q_rd,
    input  logic                       i_pop,
    output logic                       o_empty,
    output logic [rgc_pkg::IDX_W-1:0]  o_index,
    output logic                       o_is_ground
);
    logic                      r_vld;
    logic                      r_last_g;
    logic [rgc_pkg::IDX_W-1:0] r_idx;
    logic                      r_ground;
    logic                      prev_g;
    logic                      ground;

    assign o_q_rd = !i_q_stat.empty && (!r_vld || i_pop);
    assign prev_g = i_q_rdata.first ? 1'b0 : r_last_g;
    assign ground = i_q_rdata.in_local ? (prev_g || i_q_rdata.in_general) : i_q_rdata.reclass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= 1'b0;
            r_last_g <= 1'b0;
        end else begin
            if (o_q_rd) begin
                r_vld    <= 1'b1;
                r_last_g <= ground;
            end else if (i_pop) begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_idx    <= i_q_rdata.idx;
            r_ground <= ground;
        end
    end

    assign o_empty     = !r_vld;
    assign o_index     = r_idx;
    assign o_is_ground = r_ground;

endmodule

### hw/rtl/ray_ground_classifier.sv
// top level of the ray ground classifier: config registers, front, queue, back
//
//  channel | direction | transfer when          | payload
//  input   | in        | push & !full           | first_of_ray, radius_mm, height_mm, point_index
//  result  | out       | pop & !empty           | out_index, is_ground
//  config  | in        | cfg_valid & cfg_ready  | cfg_index, cfg_data
//
// one point per cycle sustained while full stays low; a point reaches the result ports through
// the stage-one register, the product register, the queue write and the result register
// full rises once QUEUE_DEPTH points sit between the input and the back end
// a stalled result side fills the queue and then holds off the input; nothing is dropped
// synchronous active-low reset clears the ray state and restores register defaults
`include "ray_ground_classifier_macros.svh"

module ray_ground_classifier #(
    parameter int QUEUE_DEPTH = rgc_pkg::QUEUE_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic                                i_first_of_ray,
    input  logic [rgc_pkg::RAD_W-1:0]           i_radius_mm,
    input  logic signed [rgc_pkg::H_W-1:0]      i_height_mm,
    input  logic [rgc_pkg::IDX_W-1:0]           i_point_index,
    output logic                                empty,
    input  logic                                pop,
    output logic [rgc_pkg::IDX_W-1:0]           o_out_index,
    output logic                                o_is_ground,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rgc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [rgc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    rgc_pkg::t_cfg     r_cfg;
    rgc_pkg::t_q_entry q_wdata;
    rgc_pkg::t_q_entry q_rdata;
    rgc_pkg::t_q_stat  q_stat;
    logic              q_wr;
    logic              q_rd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tan_local   <= rgc_pkg::RST_TAN_LOCAL;
            r_cfg.tan_general <= rgc_pkg::RST_TAN_GENERAL;
            r_cfg.min_window  <= rgc_pkg::RST_MIN_WINDOW;
            r_cfg.ring        <= rgc_pkg::RST_RING;
            r_cfg.gap         <= rgc_pkg::RST_GAP;
            r_cfg.sensor      <= rgc_pkg::RST_SENSOR;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (rgc_pkg::t_cfg_idx'(i_cfg_index))
                rgc_pkg::CFG_TAN_LOCAL:   r_cfg.tan_local   <= i_cfg_data[rgc_pkg::TAN_W-1:0];
                rgc_pkg::CFG_TAN_GENERAL: r_cfg.tan_general <= i_cfg_data[rgc_pkg::TAN_W-1:0];
                rgc_pkg::CFG_MIN_WINDOW:  r_cfg.min_window  <= i_cfg_data[rgc_pkg::WIN_W-1:0];
                rgc_pkg::CFG_RING:        r_cfg.ring        <= i_cfg_data[rgc_pkg::RAD_W-1:0];
                rgc_pkg::CFG_GAP:         r_cfg.gap         <= i_cfg_data[rgc_pkg::RAD_W-1:0];
                rgc_pkg::CFG_SENSOR:      r_cfg.sensor      <= i_cfg_data[rgc_pkg::WIN_W-1:0];
                default: ;
            endcase
        end
    end

    rgc_front #(
        .QueueDepth (QUEUE_DEPTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_push    (push),
        .i_first   (i_first_of_ray),
        .i_radius  (i_radius_mm),
        .i_height  (i_height_mm),
        .i_index   (i_point_index),
        .o_full    (full),
        .i_q_rd    (q_rd),
        .o_q_wr    (q_wr),
        .o_q_wdata (q_wdata)
    );

    rgc_queue #(
        .QueueDepth (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata (q_wdata),
        .i_rd    (q_rd),
        .o_rdata (q_rdata),
        .o_stat  (q_stat)
    );

    rgc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_rdata   (q_rdata),
        .i_q_stat    (q_stat),
        .o_q_rd      (q_rd),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_index     (o_out_index),
        .o_is_ground (o_is_ground)
    );

    // credits must keep the queue from overflowing
    `RGC_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, q_wr, !q_stat.full || q_rd, "queue overflow")
    // a queue write leaves something to read
    `RGC_ASSERT_NEXT(a_wr_fills, i_clk, i_rst_n, q_wr && !q_rd, !q_stat.empty, "queue lost a write")
    // a taken result is replaced at once when the queue holds more
    `RGC_ASSERT_NEXT(a_refill, i_clk, i_rst_n, pop && !empty && !q_stat.empty, !empty,
        "result slot not refilled")

endmodule

### dv/rgc_label_checker.sv
// checker for the ray ground classifier: predicts each label and compares the result stream
module rgc_label_checker
    import rgc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    input  logic                    full,
    input  logic                    i_first_of_ray,
    input  logic [RAD_W-1:0]        i_radius_mm,
    input  logic signed [H_W-1:0]   i_height_mm,
    input  logic [IDX_W-1:0]        i_point_index,
    input  logic                    empty,
    input  logic                    pop,
    input  logic [IDX_W-1:0]        o_out_index,
    input  logic                    o_is_ground,
    input  logic                    i_cfg_valid,
    input  logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    output int                      fail_count,
    output int                      pending_results
);

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic             ground;
    } point_label_t;

    t_cfg                  regs;
    logic [RAD_W-1:0]      ray_radius;
    logic signed [H_W-1:0] ray_height;
    logic                  ray_ground;
    point_label_t          labels_due[$];

    // (tan * run) >> 16, clipped to the height range
    function automatic longint slope_rise(input logic [TAN_W-1:0] tan_q16, input longint run);
        longint rise;
        rise = (longint'(tan_q16) * run) >> 16;
        return (rise > longint'(H_MAX)) ? longint'(H_MAX) : rise;
    endfunction

    function automatic bit in_band(input longint z, input longint centre, input longint half);
        return (z >= centre - half) && (z <= centre + half);
    endfunction

    function automatic logic label_point(input logic first, input logic [RAD_W-1:0] radius,
                                         input logic signed [H_W-1:0] height);
        longint floor_z;
        longint z;
        longint step;
        longint local_win;
        longint general_win;
        logic   ground;
        floor_z = -longint'(regs.sensor);
        z = longint'(height);
        if (first) begin
            ray_radius = '0;
            ray_height = H_W'(floor_z);
            ray_ground = 1'b0;
        end
        step = longint'(radius) - longint'(ray_radius);
        // a falling radius gives a negative, empty window
        local_win = (step >= 0) ? slope_rise(regs.tan_local, step)
                                : -slope_rise(regs.tan_local, -step);
        general_win = slope_rise(regs.tan_general, longint'(radius));
        if (step > longint'(regs.ring) && local_win < longint'(regs.min_window)) begin
            local_win = longint'(regs.min_window);
        end
        if (in_band(z, longint'(ray_height), local_win)) begin
            ground = ray_ground || in_band(z, floor_z, general_win);
        end else begin
            ground = (step > longint'(regs.gap)) && in_band(z, floor_z, local_win);
        end
        ray_radius = radius;
        ray_height = height;
        ray_ground = ground;
        return ground;
    endfunction

    always @(posedge i_clk) begin
        point_label_t due;
        if (!i_rst_n) begin
            regs.tan_local   = RST_TAN_LOCAL;
            regs.tan_general = RST_TAN_GENERAL;
            regs.min_window  = RST_MIN_WINDOW;
            regs.ring        = RST_RING;
            regs.gap         = RST_GAP;
            regs.sensor      = RST_SENSOR;
            ray_radius = '0;
            ray_height = '0;
            ray_ground = 1'b0;
            labels_due.delete();
            fail_count = 0;
        end else begin
            if (pop && !empty) begin
                if (labels_due.size() == 0) begin
                    $display("%0t: result transfer expected none, actual index %0d ground %0b",
                             $time, o_out_index, o_is_ground);
                    fail_count++;
                end else begin
                    due = labels_due.pop_front();
                    if (o_out_index !== due.index) begin
                        $display("%0t: out_index expected %0d actual %0d",
                                 $time, due.index, o_out_index);
                        fail_count++;
                    end
                    if (o_is_ground !== due.ground) begin
                        $display("%0t: is_ground of index %0d expected %0b actual %0b",
                                 $time, due.index, due.ground, o_is_ground);
                        fail_count++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TAN_LOCAL:   regs.tan_local   = i_cfg_data[TAN_W-1:0];
                    CFG_TAN_GENERAL: regs.tan_general = i_cfg_data[TAN_W-1:0];
                    CFG_MIN_WINDOW:  regs.min_window  = i_cfg_data[WIN_W-1:0];
                    CFG_RING:        regs.ring        = i_cfg_data[RAD_W-1:0];
                    CFG_GAP:         regs.gap         = i_cfg_data[RAD_W-1:0];
                    CFG_SENSOR:      regs.sensor      = i_cfg_data[WIN_W-1:0];
                    default: ;
                endcase
            end
            if (push && !full) begin
                due.index  = i_point_index;
                due.ground = label_point(i_first_of_ray, i_radius_mm, i_height_mm);
                labels_due = {labels_due, due};
            end
        end
        pending_results = labels_due.size();
    end

endmodule

### dv/tb_ray_ground_classifier.sv
// testbench top for the ray ground classifier: stimulus, configuration phases and verdict
module tb_ray_ground_classifier;
    import rgc_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_POINTS = 2000;
    localparam int PHASES        = 6;
    localparam int CALM_PHASE    = 3;
    localparam int RADIUS_MAX    = 2**RAD_W - 1;
    localparam int INDEX_MAX     = 2**IDX_W - 1;
    localparam int HEIGHT_LO     = -(2**(H_W-1));
    localparam int HEIGHT_HI     = 2**(H_W-1) - 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef enum int {SET_RESET, SET_ZERO, SET_MAX, SET_TYPICAL, SET_RANDOM} setting_t;

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  push      = 1'b0;
    logic                  first     = 1'b0;
    logic [RAD_W-1:0]      radius    = '0;
    logic signed [H_W-1:0] height    = '0;
    logic [IDX_W-1:0]      index     = '0;
    logic                  pop       = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  full;
    logic                  empty;
    logic                  cfg_ready;
    logic [IDX_W-1:0]      out_index;
    logic                  is_ground;
    int                    fail_count;
    int                    pending_results;
    int                    cycle_count = 0;
    int                    points_sent = 0;
    int                    ground_z    = -int'(RST_SENSOR);
    bit                    calm        = 1'b0;
    setting_t              schedule[PHASES] = '{SET_RESET, SET_ZERO, SET_MAX, SET_TYPICAL,
                                                SET_RANDOM, SET_TYPICAL};

    ray_ground_classifier uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_first_of_ray (first),
        .i_radius_mm    (radius),
        .i_height_mm    (height),
        .i_point_index  (index),
        .empty          (empty),
        .pop            (pop),
        .o_out_index    (out_index),
        .o_is_ground    (is_ground),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    rgc_label_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_first_of_ray  (first),
        .i_radius_mm     (radius),
        .i_height_mm     (height),
        .i_point_index   (index),
        .empty           (empty),
        .pop             (pop),
        .o_out_index     (out_index),
        .o_is_ground     (is_ground),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_ray_ground_classifier: FAIL");
            $finish;
        end
    end

    // result side stalls
    always @(negedge i_clk) begin
        pop <= i_rst_n && (calm || $urandom_range(99) >= 9);
    end

    function automatic int clip(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int spread(input int half);
        return int'($urandom_range(0, 2 * half)) - half;
    endfunction

    function automatic int any_index();
        return int'($urandom_range(0, INDEX_MAX));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] typical_setting(input t_cfg_idx which);
        case (which)
            CFG_TAN_LOCAL:   return CFG_DATA_W'($urandom_range(3000, 20000));
            CFG_TAN_GENERAL: return CFG_DATA_W'($urandom_range(2000, 12000));
            CFG_MIN_WINDOW:  return CFG_DATA_W'($urandom_range(0, 200));
            CFG_RING:        return CFG_DATA_W'($urandom_range(0, 50));
            CFG_GAP:         return CFG_DATA_W'($urandom_range(50, 1000));
            CFG_SENSOR:      return CFG_DATA_W'($urandom_range(500, 3000));
            default:         return '0;
        endcase
    endfunction

    task automatic send_point(input logic first_mark, input int r, input int h, input int idx);
        push   <= 1'b1;
        first  <= first_mark;
        radius <= RAD_W'(r);
        height <= H_W'(h);
        index  <= IDX_W'(idx);
        do @(posedge i_clk); while (full);
        points_sent++;
        @(negedge i_clk);
        if (!calm && $urandom_range(99) < 9) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
    endtask

    // one ray sorted by radius; a broken ray may lose its mark or step backward
    task automatic send_ray(input bit broken);
        int len;
        int r;
        int h;
        int step;
        int pick;
        len = $urandom_range(1, 12);
        r = ($urandom_range(9) == 0) ? int'($urandom_range(0, RADIUS_MAX))
                                     : int'($urandom_range(0, 4000));
        h = clip(ground_z + spread(100), HEIGHT_LO, HEIGHT_HI);
        for (int k = 0; k < len; k++) begin
            if (k > 0) begin
                pick = $urandom_range(99);
                if (pick < 55)      step = $urandom_range(0, 30);
                else if (pick < 85) step = $urandom_range(0, 400);
                else if (pick < 97) step = $urandom_range(150, 6000);
                else                step = $urandom_range(0, RADIUS_MAX);
                if (broken && $urandom_range(3) == 0) step = -step;
                r = clip(r + step, 0, RADIUS_MAX);
                pick = $urandom_range(99);
                if (pick < 50)      h = h + spread(20);
                else if (pick < 80) h = ground_z + spread(60);
                else                h = h + spread(2000);
                h = clip(h, HEIGHT_LO, HEIGHT_HI);
            end
            send_point((k == 0) && !(broken && $urandom_range(1)), r, h, any_index());
        end
    endtask

    task automatic send_noise();
        send_point(1'($urandom_range(1)), int'($urandom_range(0, RADIUS_MAX)),
                   int'($urandom_range(0, 2**H_W - 1)) + HEIGHT_LO, any_index());
    endtask

    task automatic drain();
        push <= 1'b0;
        while (pending_results != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] which,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        if (which == CFG_SENSOR) ground_z = -int'(value[WIN_W-1:0]);
    endtask

    task automatic reconfigure(input int phase);
        logic [CFG_DATA_W-1:0] value;
        drain();
        for (int i = 0; i <= int'(CFG_SENSOR); i++) begin
            case (schedule[phase])
                SET_ZERO:   value = '0;
                SET_MAX:    value = '1;
                SET_RANDOM: value = CFG_DATA_W'($urandom);
                default:    value = typical_setting(t_cfg_idx'(i));
            endcase
            write_reg(CFG_IDX_W'(i), value);
        end
        // indexes past the register list must be ignored
        write_reg((phase % 2) ? CFG_SPARE_HI : CFG_SPARE_LO, CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int goal;
        int pick;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed points under the reset settings
        send_point(1'b0, 100, 0, 0);                   // no ray mark right after reset
        send_point(1'b1, 1000, -1750, INDEX_MAX);
        send_point(1'b0, 1005, -1745, any_index());    // step within ring spacing
        send_point(1'b0, 1300, -1740, any_index());
        send_point(1'b0, 1310, -500, any_index());     // obstacle
        send_point(1'b0, 3000, -1750, any_index());    // back to ground after a big gap
        send_point(1'b0, 3000, -1750, any_index());    // zero step
        send_point(1'b0, 2000, -1750, any_index());    // unsorted radius
        send_point(1'b1, 0, HEIGHT_LO, 0);
        send_point(1'b0, RADIUS_MAX, HEIGHT_HI, INDEX_MAX);
        send_point(1'b1, RADIUS_MAX, HEIGHT_LO, any_index());
        send_point(1'b0, RADIUS_MAX, HEIGHT_LO, any_index());
        send_point(1'b1, 8, -1750, any_index());
        send_point(1'b0, 19, -1750, any_index());      // just past ring spacing
        send_point(1'b0, 219, -1700, any_index());     // gap equal to reclass gap
        send_point(1'b0, 420, -1750, any_index());     // gap just past reclass gap

        goal = points_sent;
        for (int phase = 0; phase < PHASES; phase++) begin
            if (schedule[phase] != SET_RESET) reconfigure(phase);
            calm <= (phase == CALM_PHASE);
            goal += RANDOM_POINTS / PHASES;
            while (points_sent < goal) begin
                pick = $urandom_range(99);
                if (pick < 78)      send_ray(1'b0);
                else if (pick < 90) send_ray(1'b1);
                else                send_noise();
            end
        end

        drain();
        repeat (8) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("tb_ray_ground_classifier: PASS");
        end else begin
            $display("tb_ray_ground_classifier: FAIL");
        end
        $finish;
    end

endmodule
